@@ src/cks_pkg.sv @@
// Shared types and constants for the color key pixel selector.
// No dependencies; used by every module under src.
package cks_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int CH_W    = 8;
  localparam int COORD_W = 12;
  localparam int MODE_W  = 3;
  localparam int KEEP_W  = 16;
  localparam int WIDTH_W = 13;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  localparam int COORD_MAX = (1 << COORD_W) - 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RED   = 3'd0,
    MODE_GREEN = 3'd1,
    MODE_BLUE  = 3'd2,
    MODE_WHITE = 3'd3,
    MODE_BLACK = 3'd4
  } mode_t;

  localparam logic [IDX_W-1:0] REG_COLOR_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COLOR_THR   = 3'd1;
  localparam logic [IDX_W-1:0] REG_WHITE_THR   = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEEP_EVERY  = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 3'd4;

  localparam logic [MODE_W-1:0]  RST_COLOR_MODE  = 3'd0;
  localparam logic [CH_W-1:0]    RST_COLOR_THR   = 8'd200;
  localparam logic [CH_W-1:0]    RST_WHITE_THR   = 8'd25;
  localparam logic [KEEP_W-1:0]  RST_KEEP_EVERY  = 16'd1;
  localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd640;

  localparam logic [CH_W-1:0] PRIMARY_CEIL = 8'd255;
  localparam int              BLACK_BASE   = 250;

  typedef struct packed {
    logic [MODE_W-1:0]  color_mode;
    logic [CH_W-1:0]    color_thr;
    logic [CH_W-1:0]    white_thr;
    logic [KEEP_W-1:0]  keep_every;
    logic [WIDTH_W-1:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } hit_t;

endpackage

@@ src/cks_cfg_regs.sv @@
// Configuration register bank with write-side clamping of rate and width.
// Depends on cks_pkg.
module cks_cfg_regs #(
  parameter int MAX_DIM = cks_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cks_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cks_pkg::DATA_W-1:0]  cfg_wdata,
  output cks_pkg::cfg_t               cfg
);

  cks_pkg::cfg_t cfg_r, cfg_nxt;
  logic [cks_pkg::WIDTH_W-1:0] width_v;

  always_comb begin
    width_v = cfg_wdata[cks_pkg::WIDTH_W-1:0];
    if (width_v == '0) begin
      width_v = cks_pkg::WIDTH_W'(1);
    end else if (32'(width_v) > 32'(MAX_DIM)) begin
      width_v = cks_pkg::WIDTH_W'(MAX_DIM);
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cks_pkg::REG_COLOR_MODE:  cfg_nxt.color_mode = cfg_wdata[cks_pkg::MODE_W-1:0];
        cks_pkg::REG_COLOR_THR:   cfg_nxt.color_thr  = cfg_wdata[cks_pkg::CH_W-1:0];
        cks_pkg::REG_WHITE_THR:   cfg_nxt.white_thr  = cfg_wdata[cks_pkg::CH_W-1:0];
        cks_pkg::REG_KEEP_EVERY: begin
          cfg_nxt.keep_every = (cfg_wdata[cks_pkg::KEEP_W-1:0] == '0) ?
                               cks_pkg::KEEP_W'(1) : cfg_wdata[cks_pkg::KEEP_W-1:0];
        end
        cks_pkg::REG_IMAGE_WIDTH: cfg_nxt.image_width = width_v;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_mode  <= cks_pkg::RST_COLOR_MODE;
      cfg_r.color_thr   <= cks_pkg::RST_COLOR_THR;
      cfg_r.white_thr   <= cks_pkg::RST_WHITE_THR;
      cfg_r.keep_every  <= cks_pkg::RST_KEEP_EVERY;
      cfg_r.image_width <= cks_pkg::RST_IMAGE_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/cks_key_match.sv @@
// Color key test of one pixel against the selected key.
// Depends on cks_pkg.
module cks_key_match (
  input  cks_pkg::cfg_t              cfg,
  input  logic [cks_pkg::CH_W-1:0]   red,
  input  logic [cks_pkg::CH_W-1:0]   green,
  input  logic [cks_pkg::CH_W-1:0]   blue,
  output logic                       match
);

  logic [cks_pkg::CH_W-1:0] t, w, lo;
  logic signed [cks_pkg::CH_W+1:0] bk;

  always_comb begin
    t  = cfg.color_thr;
    w  = cfg.white_thr;
    lo = cks_pkg::PRIMARY_CEIL - t;
    // black bound goes negative for thresholds above its base
    bk = (cks_pkg::CH_W+2)'(cks_pkg::BLACK_BASE) - $signed({2'b00, t});
    case (cfg.color_mode)
      cks_pkg::MODE_RED:   match = (red >= t) && (green < lo) && (blue < lo);
      cks_pkg::MODE_GREEN: match = (red < lo) && (green >= t) && (blue < lo);
      cks_pkg::MODE_BLUE:  match = (red < lo) && (green < lo) && (blue >= t);
      cks_pkg::MODE_WHITE: match = (red >= w) && (green >= w) && (blue >= w);
      cks_pkg::MODE_BLACK: begin
        match = ($signed({2'b00, red}) < bk) && ($signed({2'b00, green}) < bk) &&
                ($signed({2'b00, blue}) < bk);
      end
      default: match = 1'b0;
    endcase
  end

endmodule

@@ src/cks_pos_track.sv @@
// Raster position and match phase tracking; decides which matches are kept.
// Depends on cks_pkg.
module cks_pos_track #(
  parameter int MAX_DIM = cks_pkg::MAX_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cks_pkg::cfg_t cfg,
  input  logic          step,
  input  logic          frame_start,
  input  logic          match,
  output cks_pkg::hit_t hit
);

  localparam int ROW_LIM = (MAX_DIM - 1 > cks_pkg::COORD_MAX) ?
                           cks_pkg::COORD_MAX : MAX_DIM - 1;

  logic [cks_pkg::COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [cks_pkg::KEEP_W-1:0]  phase_r, phase_nxt;
  logic [cks_pkg::COORD_W-1:0] col_cur, row_cur;
  logic [cks_pkg::KEEP_W-1:0]  phase_cur;
  logic [cks_pkg::COORD_W:0]   col_inc;
  logic [cks_pkg::KEEP_W:0]    phase_inc;

  always_comb begin
    col_cur   = frame_start ? '0 : col_r;
    row_cur   = frame_start ? '0 : row_r;
    phase_cur = frame_start ? '0 : phase_r;

    hit.emit = match && (phase_cur == '0);
    hit.x    = col_cur;
    hit.y    = row_cur;

    phase_inc = {1'b0, phase_cur} + 1'b1;
    phase_nxt = phase_cur;
    if (match) begin
      phase_nxt = (phase_inc >= {1'b0, cfg.keep_every}) ? '0 :
                  phase_inc[cks_pkg::KEEP_W-1:0];
    end

    col_inc = {1'b0, col_cur} + 1'b1;
    row_nxt = row_cur;
    if (col_inc >= cfg.image_width) begin
      col_nxt = '0;
      if (row_cur < cks_pkg::COORD_W'(ROW_LIM)) begin
        row_nxt = row_cur + 1'b1;
      end
    end else begin
      col_nxt = col_inc[cks_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
    end else if (step) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ src/color_key_pixel_selector.sv @@
// Top level of the color key pixel selector: input register, key test,
// position tracking and result register. Depends on cks_pkg and all cks_ modules.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | red, green, blue level, frame_start
//   out     | output    | out_valid / out_ready | x_coord, y_coord
//   cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// One pixel per cycle sustained while no held result stalls a kept pixel; a
// request reaches the result through the input register and the result register.
// Reset clears the position, phase, valid flags and configuration defaults.
// A held result stalls only a pixel that itself matches and is kept;
// non-kept pixels keep flowing past it.
module color_key_pixel_selector #(
  parameter int MAX_DIM = cks_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cks_pkg::CH_W-1:0]     in_red_level,
  input  logic [cks_pkg::CH_W-1:0]     in_green_level,
  input  logic [cks_pkg::CH_W-1:0]     in_blue_level,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cks_pkg::COORD_W-1:0]  out_x_coord,
  output logic [cks_pkg::COORD_W-1:0]  out_y_coord,
  input  logic                         cfg_we,
  input  logic [cks_pkg::IDX_W-1:0]    cfg_index,
  input  logic [cks_pkg::DATA_W-1:0]   cfg_wdata
);

  cks_pkg::cfg_t cfg;
  cks_pkg::hit_t hit;

  logic                        pix_valid_r;
  logic [cks_pkg::CH_W-1:0]    red_r, green_r, blue_r;
  logic                        fs_r;
  logic                        match;
  logic                        advance;
  logic                        out_valid_r;
  logic [cks_pkg::COORD_W-1:0] x_r, y_r;

  cks_cfg_regs #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cks_key_match u_match (
    .cfg   (cfg),
    .red   (red_r),
    .green (green_r),
    .blue  (blue_r),
    .match (match)
  );

  cks_pos_track #(.MAX_DIM(MAX_DIM)) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step        (advance),
    .frame_start (fs_r),
    .match       (match),
    .hit         (hit)
  );

  assign advance  = pix_valid_r && (!hit.emit || !out_valid_r || out_ready);
  assign in_ready = !pix_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        pix_valid_r <= in_valid;
      end
      if (advance && hit.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red_r   <= in_red_level;
      green_r <= in_green_level;
      blue_r  <= in_blue_level;
      fs_r    <= in_frame_start;
    end
    if (advance && hit.emit) begin
      x_r <= hit.x;
      y_r <= hit.y;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x_coord = x_r;
  assign out_y_coord = y_r;

endmodule
